// File: design/crot_pkg.sv
// ----------------------------------------------------------------------------
// crot_pkg
// shared constants, codes and types of the chained range translation block
// ----------------------------------------------------------------------------
package crot_pkg;

    localparam int STAGES  = 7;
    localparam int ENTRIES = 64;
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;
    localparam int STAGE_W = 3;
    localparam int SLOT_W  = 6;

    localparam int DEPTH   = STAGES * ENTRIES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_XLATE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_XLATE,
        OP_CLEAR,
        OP_NONE
    } t_op;

    typedef struct packed {
        logic               active;
        logic [VALUE_W-1:0] src;
        logic [VALUE_W-1:0] dst;
        logic [VALUE_W-1:0] len;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  addr;
        t_entry             entry;
        logic [VALUE_W-1:0] point;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

// File: design/crot_in_if.sv
// ----------------------------------------------------------------------------
// crot_in_if
// input channel: command item with table entry fields and a point
// ----------------------------------------------------------------------------
interface crot_in_if;
    logic                          valid;
    logic                          ready;
    logic [crot_pkg::CMD_W-1:0]    cmd;
    logic [crot_pkg::STAGE_W-1:0]  stage;
    logic [crot_pkg::SLOT_W-1:0]   slot;
    logic                          entry_valid;
    logic [crot_pkg::VALUE_W-1:0]  dest_start;
    logic [crot_pkg::VALUE_W-1:0]  source_start;
    logic [crot_pkg::VALUE_W-1:0]  range_length;
    logic [crot_pkg::VALUE_W-1:0]  point;

    modport source (
        output valid, cmd, stage, slot, entry_valid,
        output dest_start, source_start, range_length, point,
        input  ready
    );
    modport sink (
        input  valid, cmd, stage, slot, entry_valid,
        input  dest_start, source_start, range_length, point,
        output ready
    );
endinterface

// File: design/crot_out_if.sv
// ----------------------------------------------------------------------------
// crot_out_if
// output channel: translated point and running minimum
// ----------------------------------------------------------------------------
interface crot_out_if;
    logic                          valid;
    logic                          ready;
    logic [crot_pkg::VALUE_W-1:0]  mapped_value;
    logic [crot_pkg::VALUE_W-1:0]  running_min;
    logic                          min_valid;

    modport source (
        output valid, mapped_value, running_min, min_valid,
        input  ready
    );
    modport sink (
        input  valid, mapped_value, running_min, min_valid,
        output ready
    );
endinterface

// File: design/chained_range_offset_translation.sv
// ----------------------------------------------------------------------------
// chained_range_offset_translation
// a point passes seven range translation stages; keeps a running minimum
// ----------------------------------------------------------------------------
// i_in carries command items (valid/ready): cmd 0 writes a range entry of a
// stage table, cmd 1 translates a point, cmd 2 clears the running minimum.
// o_out returns one result item per input item, in order.
// a decode front pushes jobs into a two-entry queue; the execution back
// takes one job at a time once the output register is free.
// writes, clears and unused commands are done in the idle state of the back.
// a translation scans each stage table through one ram read port, one entry
// per cycle, then works out the offset and applies it, stage by stage, and
// presents its result from the done state.
// the back takes the next waiting job in the cycle after the result leaves.
// the queue keeps accepting while the back works, and the output register
// holds a result until the receiver takes it.
// after reset the table memory is cleared, one entry per cycle, through all 448
// entries; i_in.ready stays low during that pass.
// a stalled receiver stalls the back, then the queue, then i_in.ready.
// ----------------------------------------------------------------------------
module chained_range_offset_translation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crot_in_if.sink     i_in,
    crot_out_if.source  o_out
);

    crot_pkg::t_job                  front_job;
    crot_pkg::t_job                  queue_job;
    crot_pkg::t_q_stat               q_stat;
    crot_pkg::t_back_stat            back_stat;
    logic                            push;
    logic                            pop;
    logic                            ram_we;
    logic [crot_pkg::ADDR_W-1:0]     ram_waddr;
    logic [crot_pkg::ADDR_W-1:0]     ram_raddr;
    crot_pkg::t_entry                ram_wdata;
    crot_pkg::t_entry                ram_rdata;
    logic [crot_pkg::ENTRY_W-1:0]    ram_rbits;

    crot_front u_front (
        .i_in        (i_in),
        .i_q_stat    (q_stat),
        .i_back_stat (back_stat),
        .o_push      (push),
        .o_job       (front_job)
    );

    crot_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_stat  (q_stat)
    );

    crot_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (queue_job),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_stat      (back_stat),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out       (o_out)
    );

    crot_ram #(
        .WIDTH (crot_pkg::ENTRY_W),
        .DEPTH (crot_pkg::DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = crot_pkg::t_entry'(ram_rbits);

endmodule

// File: design/crot_ram.sv
// ----------------------------------------------------------------------------
// crot_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module crot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/crot_front.sv
// ----------------------------------------------------------------------------
// crot_front
// accepts input items, decodes the command and builds a job for the queue
// ----------------------------------------------------------------------------
module crot_front (
    crot_in_if.sink                 i_in,
    input  crot_pkg::t_q_stat       i_q_stat,
    input  crot_pkg::t_back_stat    i_back_stat,
    output logic                    o_push,
    output crot_pkg::t_job          o_job
);

    logic in_range;

    assign i_in.ready = !i_q_stat.full && !i_back_stat.clearing;
    assign o_push     = i_in.valid && i_in.ready;

    // writes outside the table are dropped
    assign in_range = (int'(i_in.stage) < crot_pkg::STAGES)
                   && (int'(i_in.slot) < crot_pkg::ENTRIES);

    always_comb begin
        o_job.addr = crot_pkg::ADDR_W'(i_in.stage)
                   * crot_pkg::ADDR_W'(crot_pkg::ENTRIES)
                   + crot_pkg::ADDR_W'(i_in.slot);
        o_job.entry.active = i_in.entry_valid;
        o_job.entry.src    = i_in.source_start;
        o_job.entry.dst    = i_in.dest_start;
        o_job.entry.len    = i_in.range_length;
        o_job.point        = i_in.point;
        unique case (crot_pkg::t_cmd'(i_in.cmd))
            crot_pkg::CMD_WRITE: o_job.op = in_range ? crot_pkg::OP_WRITE : crot_pkg::OP_NONE;
            crot_pkg::CMD_XLATE: o_job.op = crot_pkg::OP_XLATE;
            crot_pkg::CMD_CLEAR: o_job.op = crot_pkg::OP_CLEAR;
            default:             o_job.op = crot_pkg::OP_NONE;
        endcase
    end

endmodule

// File: design/crot_queue.sv
// ----------------------------------------------------------------------------
// crot_queue
// short job fifo between the decode front and the execution back
// ----------------------------------------------------------------------------
module crot_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  crot_pkg::t_job          i_job,
    input  logic                    i_pop,
    output crot_pkg::t_job          o_job,
    output crot_pkg::t_q_stat       o_stat
);

    crot_pkg::t_job              r_mem [crot_pkg::QDEPTH];
    logic [crot_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [crot_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [crot_pkg::QPTR_W:0]   r_count;

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (crot_pkg::QPTR_W+1)'(crot_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr_ptr] <= i_job;
                r_wr_ptr        <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/crot_back.sv
// ----------------------------------------------------------------------------
// crot_back
// executes jobs: table writes, stage-by-stage translation scans, minimum
// ----------------------------------------------------------------------------
module crot_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  crot_pkg::t_job                 i_job,
    input  crot_pkg::t_q_stat              i_q_stat,
    output logic                           o_pop,
    output crot_pkg::t_back_stat           o_stat,
    output logic                           o_ram_we,
    output logic [crot_pkg::ADDR_W-1:0]    o_ram_waddr,
    output crot_pkg::t_entry               o_ram_wdata,
    output logic [crot_pkg::ADDR_W-1:0]    o_ram_raddr,
    input  crot_pkg::t_entry               i_ram_rdata,
    crot_out_if.source                     o_out
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DIFF,
        S_APPLY,
        S_DONE
    } t_state;

    localparam int VW = crot_pkg::VALUE_W;

    t_state                        r_state,     n_state;
    logic [crot_pkg::ADDR_W-1:0]   r_clr_addr,  n_clr_addr;
    logic [VW-1:0]                 r_p,         n_p;
    logic [crot_pkg::STAGE_W-1:0]  r_stage,     n_stage;
    logic [crot_pkg::IDX_W-1:0]    r_idx,       n_idx;
    logic                          r_issue,     n_issue;
    logic                          r_rd_vld,    n_rd_vld;
    logic                          r_rd_last,   n_rd_last;
    logic                          r_found,     n_found;
    crot_pkg::t_entry              r_best,      n_best;
    logic [VW-1:0]                 r_off,       n_off;
    logic [VW-1:0]                 r_min,       n_min;
    logic                          r_have,      n_have;
    logic                          r_out_valid, n_out_valid;
    logic [VW-1:0]                 r_out_mapped, n_out_mapped;
    logic [VW-1:0]                 r_out_min,   n_out_min;
    logic                          r_out_have,  n_out_have;

    logic                          take;
    logic                          hit;
    logic                          lower;
    logic [VW:0]                   sum;

    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_ram_raddr     = crot_pkg::ADDR_W'(r_stage) * crot_pkg::ADDR_W'(crot_pkg::ENTRIES)
                           + crot_pkg::ADDR_W'(r_idx);

    // candidate: active, not above the point, not below the current pick
    assign take  = i_ram_rdata.active && (i_ram_rdata.src <= r_p)
                && (!r_found || (i_ram_rdata.src >= r_best.src));
    assign hit   = r_found && (r_off < r_best.len);
    assign sum   = {1'b0, r_best.dst} + {1'b0, r_off};
    assign lower = !r_have || (r_p < r_min);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_p          = r_p;
        n_stage      = r_stage;
        n_idx        = r_idx;
        n_issue      = r_issue;
        n_rd_vld     = r_rd_vld;
        n_rd_last    = r_rd_last;
        n_found      = r_found;
        n_best       = r_best;
        n_off        = r_off;
        n_min        = r_min;
        n_have       = r_have;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_mapped = r_out_mapped;
        n_out_min    = r_out_min;
        n_out_have   = r_out_have;
        o_pop        = 1'b0;
        o_ram_we     = 1'b0;
        o_ram_waddr  = i_job.addr;
        o_ram_wdata  = i_job.entry;

        unique case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr_addr;
                o_ram_wdata = '0;
                if (r_clr_addr == crot_pkg::ADDR_W'(crot_pkg::DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (!i_q_stat.empty && !r_out_valid) begin
                    o_pop        = 1'b1;
                    n_out_mapped = '0;
                    n_out_min    = r_min;
                    n_out_have   = r_have;
                    unique case (i_job.op)
                        crot_pkg::OP_WRITE: begin
                            o_ram_we    = 1'b1;
                            n_out_valid = 1'b1;
                        end
                        crot_pkg::OP_XLATE: begin
                            n_p       = i_job.point;
                            n_stage   = '0;
                            n_idx     = '0;
                            n_issue   = 1'b1;
                            n_rd_vld  = 1'b0;
                            n_found   = 1'b0;
                            n_state   = S_SCAN;
                        end
                        crot_pkg::OP_CLEAR: begin
                            n_min       = '1;
                            n_have      = 1'b0;
                            n_out_min   = '1;
                            n_out_have  = 1'b0;
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read address issued in the cycle before the compare
                n_rd_vld  = r_issue;
                n_rd_last = r_issue
                         && (r_idx == crot_pkg::IDX_W'(crot_pkg::ENTRIES - 1));
                if (r_issue) begin
                    if (r_idx == crot_pkg::IDX_W'(crot_pkg::ENTRIES - 1)) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    if (take) begin
                        n_found = 1'b1;
                        n_best  = i_ram_rdata;
                    end
                    if (r_rd_last) begin
                        n_state = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                n_off   = r_p - r_best.src;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (hit) begin
                    n_p = sum[VW] ? '1 : sum[VW-1:0];
                end
                if (r_stage == crot_pkg::STAGE_W'(crot_pkg::STAGES - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_stage = r_stage + 1'b1;
                    n_idx   = '0;
                    n_issue = 1'b1;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_DONE: begin
                n_min        = lower ? r_p : r_min;
                n_have       = 1'b1;
                n_out_mapped = r_p;
                n_out_min    = lower ? r_p : r_min;
                n_out_have   = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_found     <= 1'b0;
            r_min       <= '1;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_p          <= n_p;
            r_stage      <= n_stage;
            r_idx        <= n_idx;
            r_issue      <= n_issue;
            r_rd_vld     <= n_rd_vld;
            r_rd_last    <= n_rd_last;
            r_found      <= n_found;
            r_best       <= n_best;
            r_off        <= n_off;
            r_min        <= n_min;
            r_have       <= n_have;
            r_out_valid  <= n_out_valid;
            r_out_mapped <= n_out_mapped;
            r_out_min    <= n_out_min;
            r_out_have   <= n_out_have;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.mapped_value = r_out_mapped;
    assign o_out.running_min  = r_out_min;
    assign o_out.min_valid    = r_out_have;

`ifndef SYNTHESIS
    a_no_result_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid
    ) else $error("result presented during table clearing pass");

    a_pop_needs_free_output: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_out_valid && r_state == S_IDLE && !i_q_stat.empty)
    ) else $error("job taken while output register occupied");

    a_done_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_out_valid && r_out_have)
    ) else $error("translation finished without a result");

    a_empty_min_is_ones: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_min == '1)
    ) else $error("running minimum not all ones while none seen");
`endif

endmodule
